### hdl/gts_pkg.sv
// Package for the go-to-goal steering core: widths, register map, modes, CORDIC angle table.
`timescale 1ns / 1ps
package gts_pkg;

  // Number of CORDIC vectoring stages (8 to 24)
  localparam int CORDIC_STAGES = 16;
  // Result bits of the square root, one per stage
  localparam int SQRT_BITS = 17;
  // Iteration stages in the pipeline
  localparam int NSTG = (CORDIC_STAGES > SQRT_BITS) ? CORDIC_STAGES : SQRT_BITS;

  // CORDIC datapath widths
  localparam int XW = 36;
  localparam int ZW = 44;
  localparam int VW = 34;
  localparam int RW = 35;

  // Register byte addresses
  localparam int AW = 5;
  localparam logic [AW-1:0] ADDR_TARGET_X   = 5'd0;
  localparam logic [AW-1:0] ADDR_TARGET_Y   = 5'd4;
  localparam logic [AW-1:0] ADDR_GAIN       = 5'd8;
  localparam logic [AW-1:0] ADDR_MAX_SPEED  = 5'd12;
  localparam logic [AW-1:0] ADDR_ARRIVE_THR = 5'd16;
  localparam logic [AW-1:0] ADDR_HEAD_THR   = 5'd20;

  typedef enum logic [1:0] {
    MODE_ARRIVED = 2'd0,
    MODE_TURN    = 2'd1,
    MODE_FORWARD = 2'd2
  } mode_e;

  localparam logic signed [1:0] TURN_POS  = 2'sb01;
  localparam logic signed [1:0] TURN_NEG  = 2'sb11;
  localparam logic signed [1:0] TURN_NONE = 2'sb00;

  localparam logic [63:0] ANG_ONE = 64'd1 << 40;

  // Shift-subtract division, used only for elaboration-time constants
  function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) scaled by 2^40
  function automatic logic signed [63:0] atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] t;
    logic signed [63:0] sum;
    p = cdiv(ANG_ONE, n);
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (p != 0) begin
        t = cdiv(p, 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - $signed(t) : sum + $signed(t);
        p = cdiv(p, n * n);
      end
    end
    return sum;
  endfunction

  // atan(2^-i) scaled by 2^40, i >= 1
  function automatic logic signed [63:0] atan_pow2(input int i);
    logic [63:0] t;
    logic signed [63:0] sum;
    sum = '0;
    for (int k = 0; k < 40; k++) begin
      if (i * (2 * k + 1) <= 40) begin
        t = cdiv(ANG_ONE >> (i * (2 * k + 1)), 64'(2 * k + 1));
        sum = (k % 2 == 1) ? sum - $signed(t) : sum + $signed(t);
      end
    end
    return sum;
  endfunction

  localparam logic signed [63:0] QUARTER = 4 * atan_inv(64'd5) - atan_inv(64'd239);
  localparam logic signed [63:0] PI_W    = 4 * QUARTER;

  function automatic logic signed [ZW-1:0] atan_tab(input int i);
    logic signed [63:0] a;
    a = (i == 0) ? QUARTER : atan_pow2(i);
    return a[ZW-1:0];
  endfunction

endpackage

### hdl/go_to_goal_steering_core.sv
// Go-to-goal steering core: pipelined distance, bearing and steering decision.
`timescale 1ns / 1ps
// Takes one pose per cycle and gives one command per pose, passing it through an input
// stage forming dx/dy, a squaring and CORDIC setup stage, NSTG stages of which the
// first SQRT_BITS each retire a square-root bit and the first CORDIC_STAGES each do
// one CORDIC vectoring step, a stage for bearing error and gain*distance, and an output
// register. The whole pipeline halts while a finished command is stalled at the output;
// otherwise a new item enters every cycle. Configuration goes through an APB-style port
// (pready always high) and is only to be written while the pipeline is empty.
module go_to_goal_steering_core import gts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // APB-style configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AW-1:0]          paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // pose input
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [15:0]     pos_x_i,
  input  logic signed [15:0]     pos_y_i,
  input  logic signed [15:0]     heading_i,
  // command output
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [14:0]            linear_velocity_o,
  output logic signed [1:0]      turn_direction_o,
  output logic [1:0]             mode_o
);

  localparam int NV = NSTG + 4;

  // configuration registers
  logic signed [15:0] tx_q, ty_q;
  logic [15:0]        gain_q;
  logic [14:0]        max_q, arr_q, hthr_q;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q   <= 16'sd256;
      ty_q   <= 16'sd256;
      gain_q <= 16'd256;
      max_q  <= 15'd768;
      arr_q  <= 15'd26;
      hthr_q <= 15'd819;
    end else if (wr_en) begin
      case (paddr)
        ADDR_TARGET_X:   tx_q   <= pwdata[15:0];
        ADDR_TARGET_Y:   ty_q   <= pwdata[15:0];
        ADDR_GAIN:       gain_q <= pwdata[15:0];
        ADDR_MAX_SPEED:  max_q  <= pwdata[14:0];
        ADDR_ARRIVE_THR: arr_q  <= pwdata[14:0];
        ADDR_HEAD_THR:   hthr_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr)
      ADDR_TARGET_X:   prdata = {16'd0, tx_q};
      ADDR_TARGET_Y:   prdata = {16'd0, ty_q};
      ADDR_GAIN:       prdata = {16'd0, gain_q};
      ADDR_MAX_SPEED:  prdata = {17'd0, max_q};
      ADDR_ARRIVE_THR: prdata = {17'd0, arr_q};
      ADDR_HEAD_THR:   prdata = {17'd0, hthr_q};
      default:         prdata = '0;
    endcase
  end

  // pipeline advance: the whole pipe holds while the output item is stalled
  logic en;
  logic [NV-1:0] vld_q;
  assign en          = ~(vld_q[NV-1] & out_stall_i);
  assign in_stall_o  = ~en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // input stage: offsets to the goal
  logic signed [16:0] dx_q, dy_q;
  logic signed [15:0] hd_in_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= 17'(tx_q) - 17'(pos_x_i);
      dy_q    <= 17'(ty_q) - 17'(pos_y_i);
      hd_in_q <= heading_i;
    end
  end

  // setup stage: squared distance, CORDIC start vector with half-turn pre-rotation
  logic [VW-1:0]          v_q   [NSTG+1];
  logic [RW-1:0]          r_q   [NSTG+1];
  logic signed [XW-1:0]   x_q   [NSTG+1];
  logic signed [XW-1:0]   y_q   [NSTG+1];
  logic signed [ZW-1:0]   z_q   [NSTG+1];
  logic signed [15:0]     hd_q  [NSTG+1];

  logic signed [33:0] sqx, sqy;
  logic signed [XW-1:0] x0, y0;
  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;
  assign x0  = {{(XW-33){dx_q[16]}}, dx_q, 16'd0};
  assign y0  = {{(XW-33){dy_q[16]}}, dy_q, 16'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[0]  <= VW'(sqx) + VW'(sqy);
      r_q[0]  <= '0;
      hd_q[0] <= hd_in_q;
      if (dx_q < 0) begin
        x_q[0] <= -x0;
        y_q[0] <= -y0;
        z_q[0] <= (dy_q >= 0) ? PI_W[ZW-1:0] : -PI_W[ZW-1:0];
      end else begin
        x_q[0] <= x0;
        y_q[0] <= y0;
        z_q[0] <= '0;
      end
    end
  end

  // iteration stages: a root bit in each of the first SQRT_BITS, a vectoring step in each of the first CORDIC_STAGES
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    localparam logic [RW-1:0] BIT = (k < SQRT_BITS) ?
                                    (RW'(1) << (2 * (SQRT_BITS - 1 - k))) : '0;
    localparam logic signed [ZW-1:0] ANG = atan_tab(k);
    logic [RW-1:0] trial;
    assign trial = r_q[k] + BIT;

    always_ff @(posedge clk_i) begin
      if (en) begin
        hd_q[k+1] <= hd_q[k];
        if (k < SQRT_BITS) begin
          if ({1'b0, v_q[k]} >= trial) begin
            v_q[k+1] <= v_q[k] - trial[VW-1:0];
            r_q[k+1] <= (r_q[k] >> 1) + BIT;
          end else begin
            v_q[k+1] <= v_q[k];
            r_q[k+1] <= r_q[k] >> 1;
          end
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k];
        end
        if (k < CORDIC_STAGES) begin
          if (y_q[k] < 0) begin
            x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
            y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
            z_q[k+1] <= z_q[k] - ANG;
          end else begin
            x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
            y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
            z_q[k+1] <= z_q[k] + ANG;
          end
        end else begin
          x_q[k+1] <= x_q[k];
          y_q[k+1] <= y_q[k];
          z_q[k+1] <= z_q[k];
        end
      end
    end
  end

  // decision stage: rounded bearing error, arrival test, speed product
  logic [16:0]         dist_val;
  logic signed [ZW-1:0] zr;
  logic signed [17:0]  brg, err, mag;
  assign dist_val = r_q[NSTG][16:0];
  assign zr   = z_q[NSTG] + (ZW'(1) <<< 27);
  assign brg  = 18'(zr >>> 28);
  assign err  = brg - 18'(hd_q[NSTG]);
  assign mag  = (err < 0) ? -err : err;

  logic        arrived_q, turn_q, pos_q;
  logic [32:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      arrived_q <= dist_val <= {2'd0, arr_q};
      turn_q    <= mag > $signed({3'd0, hthr_q});
      pos_q     <= err > 0;
      prod_q    <= gain_q * dist_val;
    end
  end

  // output register
  logic [24:0] lin;
  assign lin = prod_q[32:8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (arrived_q) begin
        linear_velocity_o <= '0;
        turn_direction_o  <= TURN_NONE;
        mode_o            <= MODE_ARRIVED;
      end else if (turn_q) begin
        linear_velocity_o <= '0;
        turn_direction_o  <= pos_q ? TURN_POS : TURN_NEG;
        mode_o            <= MODE_TURN;
      end else begin
        linear_velocity_o <= (lin > {10'd0, max_q}) ? max_q : lin[14:0];
        turn_direction_o  <= TURN_NONE;
        mode_o            <= MODE_FORWARD;
      end
    end
  end

endmodule
